// ===== hw/rtl/awfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ALU with flags package
// Shared types and codes for the flag-keeping ALU and its condition unit.
// ----------------------------------------------------------------------------
package awfc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned ActionW  = 4;
  localparam int unsigned CondW    = 4;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;

  localparam logic [DataW-1:0] SignBit = 32'h8000_0000;

  typedef enum logic [ActionW-1:0] {
    ACT_ADD  = 4'd0,
    ACT_OR   = 4'd1,
    ACT_AND  = 4'd2,
    ACT_SUB  = 4'd3,
    ACT_XOR  = 4'd4,
    ACT_CMP  = 4'd5,
    ACT_TEST = 4'd6,
    ACT_INC  = 4'd7,
    ACT_DEC  = 4'd8,
    ACT_MUL  = 4'd9,
    ACT_COND = 4'd10
  } action_e;

  typedef enum logic [CondW-1:0] {
    CC_O  = 4'd0,
    CC_NO = 4'd1,
    CC_B  = 4'd2,
    CC_NB = 4'd3,
    CC_E  = 4'd4,
    CC_NE = 4'd5,
    CC_BE = 4'd6,
    CC_A  = 4'd7,
    CC_S  = 4'd8,
    CC_NS = 4'd9,
    CC_P  = 4'd10,
    CC_NP = 4'd11,
    CC_L  = 4'd12,
    CC_GE = 4'd13,
    CC_LE = 4'd14,
    CC_G  = 4'd15
  } cond_e;

  typedef struct packed {
    logic overflow;
    logic sign;
    logic zero;
    logic carry;
  } flags_t;

  typedef struct packed {
    logic [CondW-1:0]   cond_code;
    logic [DataW-1:0]   operand_b;
    logic [DataW-1:0]   operand_a;
    logic [ActionW-1:0] action;
  } req_t;

  typedef struct packed {
    logic             cond_true;
    flags_t           flags;
    logic             write_back;
    logic [DataW-1:0] result;
  } rsp_t;

endpackage

// ===== hw/rtl/alu_with_flags_and_conditions_top.sv =====
// ----------------------------------------------------------------------------
// ALU with flags and conditions, top level
// Takes one request per cycle while results drain; returns results with new flags.
// ----------------------------------------------------------------------------
// A request enters an input register; the ALU and condition logic then work
// between that register and the result register, which presents the result.
// One request is accepted every cycle while the result side keeps taking
// results. The carry, zero, sign and overflow flags live in one register that
// is updated as a request moves into the result register, so each request
// sees the flags left by the one before.
module alu_with_flags_and_conditions_top import awfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // action[3:0], operand_a[35:4], operand_b[67:36], cond_code[71:68]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // result[31:0], write_back[32], carry[33], zero[34], sign[35],
  // overflow[36], cond_true[37], zero fill [39:38]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic   in_valid_q;
  req_t   in_q;
  logic   out_valid_q;
  rsp_t   out_q;
  flags_t flags_q;
  rsp_t   rsp;
  logic   advance;
  logic   in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  awfc_exec u_exec (
    .req_i   (in_q),
    .flags_i (flags_q),
    .rsp_o   (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        flags_q     <= rsp.flags;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= req_t'(s_axis_tdata_i);
    end
    if (advance) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(rsp_t)){1'b0}}, out_q};

  // Flags change only when a request moves into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flags changed without a request completing");

  // A condition check leaves the flags alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.action == ACT_COND) |=> $stable(flags_q))
    else $error("condition check modified the flags");

  // Only a condition check can report a met condition.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.action != ACT_COND) |=> !out_q.cond_true)
    else $error("cond_true set by a non-condition request");

  // A completing request always produces a valid result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o && (m_axis_tdata_o[36:33] == flags_q))
    else $error("result missing or flags in result do not match flag register");

endmodule

// ===== hw/rtl/awfc_cond.sv =====
// ----------------------------------------------------------------------------
// Condition evaluator
// Evaluates an x86 condition code against the current status flags.
// ----------------------------------------------------------------------------
module awfc_cond import awfc_pkg::*; (
  input  logic [CondW-1:0] cond_code_i,
  input  flags_t           flags_i,
  output logic             cond_true_o
);

  logic so_differ;

  assign so_differ = flags_i.sign ^ flags_i.overflow;

  always_comb begin
    case (cond_e'(cond_code_i))
      CC_O:    cond_true_o = flags_i.overflow;
      CC_NO:   cond_true_o = !flags_i.overflow;
      CC_B:    cond_true_o = flags_i.carry;
      CC_NB:   cond_true_o = !flags_i.carry;
      CC_E:    cond_true_o = flags_i.zero;
      CC_NE:   cond_true_o = !flags_i.zero;
      CC_BE:   cond_true_o = flags_i.carry || flags_i.zero;
      CC_A:    cond_true_o = !flags_i.carry && !flags_i.zero;
      CC_S:    cond_true_o = flags_i.sign;
      CC_NS:   cond_true_o = !flags_i.sign;
      // Parity is not tracked: P never holds and NP always does.
      CC_P:    cond_true_o = 1'b0;
      CC_NP:   cond_true_o = 1'b1;
      CC_L:    cond_true_o = so_differ;
      CC_GE:   cond_true_o = !so_differ;
      CC_LE:   cond_true_o = flags_i.zero || so_differ;
      CC_G:    cond_true_o = !flags_i.zero && !so_differ;
      default: cond_true_o = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/awfc_exec.sv =====
// ----------------------------------------------------------------------------
// ALU execute unit
// Computes the result, write-back enable and next flags for one request.
// ----------------------------------------------------------------------------
module awfc_exec import awfc_pkg::*; (
  input  req_t   req_i,
  input  flags_t flags_i,
  output rsp_t   rsp_o
);

  logic [DataW:0]     add_sum;
  logic [DataW:0]     sub_diff;
  logic [DataW-1:0]   a;
  logic [DataW-1:0]   b;
  logic [DataW-1:0]   mul_lo;
  logic [DataW-1:0]   res;
  logic               cond_ok;
  flags_t             fl;

  assign a        = req_i.operand_a;
  assign b        = req_i.operand_b;
  assign add_sum  = {1'b0, a} + {1'b0, b};
  assign sub_diff = {1'b0, a} - {1'b0, b};
  assign mul_lo   = a * b;

  awfc_cond u_cond (
    .cond_code_i (req_i.cond_code),
    .flags_i     (flags_i),
    .cond_true_o (cond_ok)
  );

  always_comb begin
    res              = '0;
    fl               = flags_i;
    rsp_o.write_back = 1'b0;
    rsp_o.cond_true  = 1'b0;
    case (action_e'(req_i.action))
      ACT_ADD: begin
        res              = add_sum[DataW-1:0];
        fl.carry         = add_sum[DataW];
        fl.overflow      = |(~(a ^ b) & (a ^ res) & SignBit);
        rsp_o.write_back = 1'b1;
      end
      ACT_SUB, ACT_CMP: begin
        res              = sub_diff[DataW-1:0];
        fl.carry         = sub_diff[DataW];
        fl.overflow      = |((a ^ b) & (a ^ res) & SignBit);
        rsp_o.write_back = (action_e'(req_i.action) == ACT_SUB);
      end
      ACT_OR, ACT_AND, ACT_XOR, ACT_TEST: begin
        if (action_e'(req_i.action) == ACT_OR) begin
          res = a | b;
        end else if (action_e'(req_i.action) == ACT_XOR) begin
          res = a ^ b;
        end else begin
          res = a & b;
        end
        fl.carry         = 1'b0;
        fl.overflow      = 1'b0;
        rsp_o.write_back = (action_e'(req_i.action) != ACT_TEST);
      end
      ACT_INC: begin
        res              = a + DataW'(1);
        rsp_o.write_back = 1'b1;
      end
      ACT_DEC: begin
        res              = a - DataW'(1);
        rsp_o.write_back = 1'b1;
      end
      ACT_MUL: begin
        res              = mul_lo;
        rsp_o.write_back = 1'b1;
      end
      ACT_COND: begin
        rsp_o.cond_true  = cond_ok;
        rsp_o.write_back = cond_ok;
        res              = cond_ok ? b : a;
      end
      default: begin
        res = '0;
      end
    endcase
    if ((action_e'(req_i.action) != ACT_COND) && (req_i.action <= ActionW'(ACT_COND))) begin
      fl.zero = (res == '0);
      fl.sign = res[DataW-1];
    end
    rsp_o.result = res;
    rsp_o.flags  = fl;
  end

endmodule

// ===== tb/alu_result_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ALU result monitor
// Watches the request and result streams of the flag-keeping ALU. It keeps
// its own copy of the status flags, works out the result of every accepted
// request and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module alu_result_monitor import awfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  // action[3:0], operand_a[35:4], operand_b[67:36], cond_code[71:68]
  input  logic [InDataW-1:0]  s_data_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  // result[31:0], write_back[32], carry[33], zero[34], sign[35],
  // overflow[36], cond_true[37], zero fill [39:38]
  input  logic [OutDataW-1:0] m_data_i,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o,
  output int unsigned         compared_o
);

  rsp_t        alu_results_q[$];
  flags_t      flags_q;
  int unsigned fail_cnt = 0;
  int unsigned compared = 0;

  function automatic logic cond_holds(logic [CondW-1:0] cc, flags_t f);
    case (cc)
      CC_O:    return f.overflow;
      CC_NO:   return !f.overflow;
      CC_B:    return f.carry;
      CC_NB:   return !f.carry;
      CC_E:    return f.zero;
      CC_NE:   return !f.zero;
      CC_BE:   return f.carry || f.zero;
      CC_A:    return !f.carry && !f.zero;
      CC_S:    return f.sign;
      CC_NS:   return !f.sign;
      CC_P:    return 1'b0;
      CC_NP:   return 1'b1;
      CC_L:    return f.sign != f.overflow;
      CC_GE:   return f.sign == f.overflow;
      CC_LE:   return f.zero || (f.sign != f.overflow);
      default: return !f.zero && (f.sign == f.overflow);
    endcase
  endfunction

  function automatic rsp_t alu_outcome(req_t req, flags_t cur);
    rsp_t             o;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] r;
    logic [63:0]      prod;
    logic             upd_zs;
    a      = req.operand_a;
    b      = req.operand_b;
    r      = '0;
    o      = '0;
    o.flags = cur;
    upd_zs = 1'b1;
    case (req.action)
      ACT_ADD: begin
        r = a + b;
        o.flags.carry    = (r < a);
        o.flags.overflow = ~(a[DataW-1] ^ b[DataW-1]) & (a[DataW-1] ^ r[DataW-1]);
        o.write_back     = 1'b1;
      end
      ACT_SUB, ACT_CMP: begin
        r = a - b;
        o.flags.carry    = (a < b);
        o.flags.overflow = (a[DataW-1] ^ b[DataW-1]) & (a[DataW-1] ^ r[DataW-1]);
        o.write_back     = (req.action == ACT_SUB);
      end
      ACT_OR, ACT_AND, ACT_XOR, ACT_TEST: begin
        if (req.action == ACT_OR) begin
          r = a | b;
        end else if (req.action == ACT_XOR) begin
          r = a ^ b;
        end else begin
          r = a & b;
        end
        o.flags.carry    = 1'b0;
        o.flags.overflow = 1'b0;
        o.write_back     = (req.action != ACT_TEST);
      end
      ACT_INC, ACT_DEC, ACT_MUL: begin
        prod = a * b;
        if (req.action == ACT_INC) begin
          r = a + DataW'(1);
        end else if (req.action == ACT_DEC) begin
          r = a - DataW'(1);
        end else begin
          r = prod[DataW-1:0];
        end
        o.write_back = 1'b1;
      end
      ACT_COND: begin
        o.cond_true  = cond_holds(req.cond_code, cur);
        r            = o.cond_true ? b : a;
        o.write_back = o.cond_true;
        upd_zs       = 1'b0;
      end
      default: begin
        upd_zs = 1'b0;
      end
    endcase
    if (upd_zs) begin
      o.flags.zero = (r == '0);
      o.flags.sign = r[DataW-1];
    end
    o.result = r;
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH at result %0d: %s", $time, compared, msg);
    fail_cnt++;
  endtask

  task automatic check_field(string name, logic [DataW-1:0] got, logic [DataW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      flags_q = '0;
      alu_results_q.delete();
    end else begin
      if (s_valid_i && s_ready_i) begin
        want    = alu_outcome(req_t'(s_data_i), flags_q);
        flags_q = want.flags;
        alu_results_q.push_back(want);
      end
      if (m_valid_i && m_ready_i) begin
        if (alu_results_q.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with no request waiting", m_data_i));
        end else begin
          want = alu_results_q.pop_front();
          got  = rsp_t'(m_data_i[$bits(rsp_t)-1:0]);
          check_field("result", got.result, want.result);
          check_field("write_back", DataW'(got.write_back), DataW'(want.write_back));
          check_field("carry", DataW'(got.flags.carry), DataW'(want.flags.carry));
          check_field("zero", DataW'(got.flags.zero), DataW'(want.flags.zero));
          check_field("sign", DataW'(got.flags.sign), DataW'(want.flags.sign));
          check_field("overflow", DataW'(got.flags.overflow),
                      DataW'(want.flags.overflow));
          check_field("cond_true", DataW'(got.cond_true), DataW'(want.cond_true));
          check_field("fill", DataW'(m_data_i[OutDataW-1:$bits(rsp_t)]), '0);
          compared++;
        end
      end
    end
    fail_cnt_o <= fail_cnt;
    pending_o  <= alu_results_q.size();
    compared_o <= compared;
  end

endmodule

// ===== tb/alu_with_flags_and_conditions_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ALU with flags and conditions testbench
// Sends directed corner requests, then random flag-setting operations each
// followed by condition checks, mixed with any-action requests; input is
// bursty and the result side stalls, once long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module alu_with_flags_and_conditions_top_tb;
  import awfc_pkg::*;

  localparam int unsigned         RandomCount = 750;
  localparam int unsigned         StallLimit  = 3000;
  localparam int unsigned         HoldOffLen  = 300;
  localparam int unsigned         HoldOffAt   = 300;
  localparam logic [ActionW-1:0]  ActSpareLo  = 4'd11;
  localparam logic [ActionW-1:0]  ActSpareHi  = 4'd15;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                s_valid;
  logic                s_ready;
  logic [InDataW-1:0]  s_data;
  logic                m_valid;
  logic                m_ready;
  logic [OutDataW-1:0] m_data;
  int unsigned         fail_cnt;
  int unsigned         pending;
  int unsigned         compared;

  req_t        alu_requests_q[$];
  int unsigned sent_cnt = 0;
  int unsigned cond_cnt = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  alu_with_flags_and_conditions_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  alu_result_monitor u_result_monitor (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_valid_i  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_i   (s_data),
    .m_valid_i  (m_valid),
    .m_ready_i  (m_ready),
    .m_data_i   (m_data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .compared_o (compared)
  );

  task automatic add_req(logic [ActionW-1:0] act, logic [DataW-1:0] a, logic [DataW-1:0] b,
                         logic [CondW-1:0] cc);
    req_t r;
    r.action    = act;
    r.operand_a = a;
    r.operand_b = b;
    r.cond_code = cc;
    alu_requests_q.push_back(r);
    if (act == ACT_COND) begin
      cond_cnt++;
    end
  endtask

  function automatic logic [DataW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'h7FFF_FFFF;
          3:       return SignBit;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1:       return $urandom_range(0, 15);
      2:       return SignBit | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The result side rotates through four stall patterns and holds off
  // once for a long stretch while the sender keeps offering requests.
  initial begin : sink
    int unsigned cyc;
    bit          held;
    m_ready <= 1'b0;
    cyc  = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && sent_cnt >= HoldOffAt) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk);
      end else begin
        case ((cyc / 80) % 4)
          0:       m_ready <= 1'b1;
          1:       m_ready <= ($urandom_range(0, 1) == 1);
          2:       m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= ((cyc % 8) < 5);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: %0d cycles without a request or result moving", quiet);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int unsigned      burst;
    int unsigned      gap;
    int unsigned      total;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    s_valid <= 1'b0;
    s_data  <= '0;

    // Wrap, borrow and signed overflow on add and subtract.
    add_req(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0001, CC_O);
    add_req(ACT_ADD, 32'h7FFF_FFFF, 32'h0000_0001, CC_NO);
    add_req(ACT_ADD, 32'h0000_0000, 32'h0000_0000, CC_B);
    add_req(ACT_SUB, 32'h0000_0000, 32'h0000_0001, CC_NB);
    add_req(ACT_SUB, SignBit, 32'h0000_0001, CC_E);
    add_req(ACT_CMP, 32'h1234_5678, 32'h1234_5678, CC_NE);
    add_req(ACT_CMP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, CC_BE);
    // Logic operations clear carry and overflow; test writes nothing back.
    add_req(ACT_OR,   32'hFFFF_FFFF, 32'h0000_0000, CC_A);
    add_req(ACT_AND,  32'hFFFF_0000, 32'h0000_FFFF, CC_S);
    add_req(ACT_XOR,  32'hA5A5_A5A5, 32'h5A5A_5A5A, CC_NS);
    add_req(ACT_TEST, 32'hFFFF_FFFF, SignBit, CC_P);
    // Inc, dec and multiply keep carry and overflow from the step before.
    add_req(ACT_ADD, SignBit, SignBit, CC_NP);
    add_req(ACT_INC, 32'hFFFF_FFFF, 32'h0000_0000, CC_L);
    add_req(ACT_COND, 32'h1111_1111, 32'h2222_2222, CC_O);
    add_req(ACT_COND, 32'h1111_1111, 32'h2222_2222, CC_B);
    add_req(ACT_DEC, 32'h0000_0000, 32'hFFFF_FFFF, CC_GE);
    add_req(ACT_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CC_LE);
    add_req(ACT_MUL, SignBit, 32'h0000_0002, CC_G);
    // Parity conditions are fixed, false and true.
    add_req(ACT_COND, 32'hFFFF_FFFF, 32'h0000_0000, CC_P);
    add_req(ACT_COND, 32'hFFFF_FFFF, 32'h0000_0000, CC_NP);
    add_req(ACT_COND, 32'h0000_0000, 32'hFFFF_FFFF, CC_LE);
    add_req(ACT_COND, 32'h0000_0000, 32'hFFFF_FFFF, CC_G);
    // Unused action codes do nothing.
    add_req(ActSpareLo, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CC_G);
    add_req(ActSpareHi, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CC_G);

    total = alu_requests_q.size() + RandomCount;
    while (alu_requests_q.size() < total) begin
      if ($urandom_range(0, 9) < 7) begin
        a = rand_operand();
        b = ($urandom_range(0, 4) == 0) ? a : rand_operand();
        add_req(ActionW'($urandom_range(ACT_ADD, ACT_MUL)), a, b,
                CondW'($urandom_range(0, 15)));
        add_req(ACT_COND, $urandom, $urandom, CondW'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) == 0) begin
          add_req(ACT_COND, $urandom, $urandom, CondW'($urandom_range(0, 15)));
        end
      end else begin
        add_req(ActionW'($urandom_range(0, 15)), rand_operand(), rand_operand(),
                CondW'($urandom_range(0, 15)));
      end
    end

    wait (rst_n);
    @(posedge clk);
    while (sent_cnt < alu_requests_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent_cnt < alu_requests_q.size()) begin
        s_valid <= 1'b1;
        s_data  <= alu_requests_q[sent_cnt];
        do @(posedge clk); while (!s_ready);
        sent_cnt++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d requests, %0d of them condition checks, over all actions.",
             sent_cnt, cond_cnt);
    $display("Compared %0d results under bursty input and stalled output.", compared);
    if (fail_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
